FILE: rtl/rv32s_pkg.sv
// Shared constants, codes and types of the RV32I-subset step core.
package rv32s_pkg;

  localparam logic [32:0] RAM_BYTES = 33'd65536;
  localparam logic [31:0] RAM_BASE  = 32'h1000_0000;
  localparam logic [31:0] RESET_PC  = 32'h0000_1000;
  localparam logic [31:0] RAM_END   = 32'(RAM_BASE + RAM_BYTES);

  localparam int RAM_WORDS = int'((RAM_BYTES + 33'd3) >> 2);
  localparam int ROW_W     = $clog2(RAM_WORDS);

  localparam logic [7:0] RAM_FILL = 8'hAA;

  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_CUSTOM = 7'b0001011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] FUNCT7_SUB = 7'b0100000;
  localparam logic [31:0] LUI_MASK  = 32'hFFFF_F000;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_ASSERT = 3'd2;
  localparam logic [2:0] ST_BADOP  = 3'd3;
  localparam logic [2:0] ST_BADFN  = 3'd4;
  localparam logic [2:0] ST_RANGE  = 3'd5;

  // Request to the four byte banks of the data RAM.
  typedef struct packed {
    logic [3:0][ROW_W-1:0] row;
    logic [3:0][7:0]       wdata;
    logic [3:0]            we;
    logic                  re;
  } dmem_req_t;

endpackage

FILE: rtl/rv32s_if.sv
// Valid/ready channel interfaces for instruction words and step results.
interface rv32s_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface rv32s_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] next_pc;
  logic        wrote_reg;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic [31:0] assert_left;
  logic [31:0] assert_right;

  modport source (output valid, output status, output next_pc, output wrote_reg,
                  output dest_index, output dest_value, output assert_left,
                  output assert_right, input ready);
  modport sink (input valid, input status, input next_pc, input wrote_reg,
                input dest_index, input dest_value, input assert_left,
                input assert_right, output ready);
endinterface

FILE: rtl/rv32s_dmem.sv
// Data RAM: four byte banks with registered read and a fill pass after reset.
module rv32s_dmem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rv32s_pkg::dmem_req_t       req_i,
  output logic [3:0][7:0]            rdata_o,
  output logic                       busy_o
);
  import rv32s_pkg::*;

  logic [ROW_W-1:0] clr_q;
  logic             busy_q;
  logic [3:0][7:0]  rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == ROW_W'(RAM_WORDS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0] mem [RAM_WORDS];

    always_ff @(posedge clk_i) begin
      if (busy_q) begin
        mem[clr_q] <= RAM_FILL;
      end else if (req_i.we[j]) begin
        mem[req_i.row[j]] <= req_i.wdata[j];
      end
      if (req_i.re) begin
        rdata_q[j] <= mem[req_i.row[j]];
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

FILE: rtl/rv32i_subset_instruction_step_core.sv
// Top level: RV32I-subset core executing one fetched instruction word per transaction.
//
//  channel   dir  payload                                   handshake
//  instr_i   in   instr_word                                valid/ready
//  result_o  out  status, next_pc, wrote_reg, dest_index,   valid/ready
//                 dest_value, assert_left, assert_right
//
// An instruction is registered on accept and executed from the execute register;
// most results are registered from there, one instruction per cycle while the output
// is not stalled. Loads add a memory stage for the synchronous data RAM read and
// block accepts while in execute. After reset the data RAM fill pass writes all
// RAM_WORDS (16384) rows with instr_i.ready low. Output stalls hold the pipeline;
// one result may wait while the next instruction sits in the execute register.
module rv32i_subset_instruction_step_core (
  input  logic clk_i,
  input  logic rst_ni,
  rv32s_instr_if.sink    instr_i,
  rv32s_result_if.source result_o
);
  import rv32s_pkg::*;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic [31:0] x,
                                      input logic [31:0] y, input logic arith,
                                      input logic sub);
    logic [4:0]  sh;
    logic [31:0] r;
    begin
      sh = y[4:0];
      unique case (f3)
        3'd0: r = sub ? x - y : x + y;
        3'd1: r = x << sh;
        3'd2: r = {31'b0, $signed(x) < $signed(y)};
        3'd3: r = {31'b0, x < y};
        3'd4: r = x ^ y;
        3'd5: r = arith ? 32'($signed(x) >>> sh) : x >> sh;
        3'd6: r = x | y;
        default: r = x & y;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] reg_reset(input logic [4:0] idx);
    logic [31:0] r;
    begin
      r = '0;
      if (idx == 5'd2) r = RAM_END;
      if (idx == 5'd3) r = RAM_BASE;
      return r;
    end
  endfunction

  // Register file, pc and stop state
  logic [31:0] rf [32];
  logic [31:0] rf_vld_q;
  logic [31:0] pc_q;
  logic [2:0]  stop_q;

  // Execute stage
  logic        e_valid_q;
  logic [31:0] instr_q, rs1_q, rs2_q;

  // Memory stage (loads only)
  logic        m_valid_q;
  logic [4:0]  m_rd_q;
  logic [2:0]  m_f3_q;
  logic [1:0]  m_lo_q;
  logic [31:0] m_npc_q;

  // Result register
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_npc_q, out_val_q, out_left_q, out_right_q;
  logic        out_wr_q;
  logic [4:0]  out_idx_q;

  dmem_req_t       dreq;
  logic [3:0][7:0] drdata;
  logic            dbusy;

  rv32s_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dreq),
    .rdata_o (drdata),
    .busy_o  (dbusy)
  );

  // Decode and execute
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_j;
  logic [2:0]  st;
  logic [31:0] npc, val, left, right, addr, off;
  logic        wr, is_load, is_store, take;
  logic [2:0]  size;
  logic        in_range;

  always_comb begin
    opc   = instr_q[6:0];
    f3    = instr_q[14:12];
    f7    = instr_q[31:25];
    rd    = instr_q[11:7];
    imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
    imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
    imm_b = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
             instr_q[11:8], 1'b0};
    imm_j = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
             instr_q[30:21], 1'b0};
    st       = ST_OK;
    npc      = pc_q + 32'd4;
    val      = '0;
    left     = '0;
    right    = '0;
    wr       = 1'b0;
    is_load  = 1'b0;
    is_store = 1'b0;
    take     = 1'b0;
    addr     = rs1_q + imm_i;
    size     = 3'd4;
    unique case (opc)
      OPC_OP: begin
        if (f7 != '0 && (f3 != 3'd0 || f7 != FUNCT7_SUB)) begin
          st = ST_BADFN;
        end else begin
          val = alu(f3, rs1_q, rs2_q, 1'b0, f7 == FUNCT7_SUB);
          wr  = 1'b1;
        end
      end
      OPC_OP_IMM: begin
        val = alu(f3, rs1_q, imm_i, instr_q[30], 1'b0);
        wr  = 1'b1;
      end
      OPC_LOAD: begin
        size    = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
        is_load = 1'b1;
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) st = ST_BADFN;
      end
      OPC_STORE: begin
        addr     = rs1_q + imm_s;
        size     = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
        is_store = 1'b1;
        if (f3 > 3'd2) st = ST_BADFN;
      end
      OPC_BRANCH: begin
        unique case (f3)
          3'd0: take = rs1_q == rs2_q;
          3'd1: take = rs1_q != rs2_q;
          3'd4: take = $signed(rs1_q) < $signed(rs2_q);
          3'd5: take = $signed(rs1_q) >= $signed(rs2_q);
          3'd6: take = rs1_q < rs2_q;
          3'd7: take = rs1_q >= rs2_q;
          default: st = ST_BADFN;
        endcase
        if (take) npc = pc_q + imm_b;
      end
      OPC_JAL: begin
        val = pc_q + 32'd4;
        wr  = 1'b1;
        npc = pc_q + imm_j;
      end
      OPC_JALR: begin
        npc = rs1_q + imm_i;
        val = pc_q + 32'd4;
        wr  = 1'b1;
      end
      OPC_LUI: begin
        val = instr_q & LUI_MASK;
        wr  = 1'b1;
      end
      OPC_CUSTOM: begin
        if (f3 == 3'd0) begin
          if (rs1_q != rs2_q) begin
            st    = ST_ASSERT;
            left  = rs1_q;
            right = rs2_q;
          end
        end else if (f3 == 3'd7) begin
          st = ST_HALT;
        end else begin
          st = ST_BADFN;
        end
      end
      default: st = ST_BADOP;
    endcase
    off      = addr - RAM_BASE;
    in_range = ({1'b0, off} + {30'b0, size}) <= RAM_BYTES;
    if ((is_load || is_store) && st == ST_OK && !in_range) st = ST_RANGE;
  end

  logic e_run, e_ok, e_to_m, out_free, m_go, e_go, e_out;

  assign e_run    = (stop_q == ST_OK);
  assign e_ok     = e_run && (st == ST_OK);
  assign e_to_m   = e_ok && is_load;
  assign out_free = !out_valid_q || result_o.ready;
  assign m_go     = m_valid_q && out_free;
  // The memory stage drains before anything behind it moves on.
  assign e_go     = e_valid_q && !m_valid_q && (e_to_m || out_free);
  assign e_out    = e_go && !e_to_m;

  assign instr_i.ready = !dbusy && (!m_valid_q || m_go)
                       && (!e_valid_q || e_out);

  logic in_acc;
  assign in_acc = instr_i.valid && instr_i.ready;

  // RAM requests: byte k of the access lands in bank (off + k) mod 4
  always_comb begin
    logic [1:0] k;
    dreq    = '0;
    dreq.re = e_go && e_to_m;
    for (int j = 0; j < 4; j++) begin
      k = 2'(j) - off[1:0];
      dreq.row[j]   = off[ROW_W+1:2] + ROW_W'(2'(j) < off[1:0]);
      dreq.wdata[j] = rs2_q[{k, 3'b000} +: 8];
      dreq.we[j]    = e_go && e_ok && is_store && ({1'b0, k} < size);
    end
  end

  // Load data assembly
  logic [31:0] ld_raw, ld_val;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_raw[8*k +: 8] = drdata[2'(m_lo_q + 2'(k))];
    end
    unique case (m_f3_q[1:0])
      2'd0:    ld_val = {{24{ld_raw[7] & !m_f3_q[2]}}, ld_raw[7:0]};
      2'd1:    ld_val = {{16{ld_raw[15] & !m_f3_q[2]}}, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  // Register file write port
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  always_comb begin
    if (m_go) begin
      rf_we = (m_rd_q != '0);
      rf_wa = m_rd_q;
      rf_wd = ld_val;
    end else begin
      rf_we = e_out && e_ok && wr && (rd != '0);
      rf_wa = rd;
      rf_wd = val;
    end
  end

  logic [4:0] rs1_a, rs2_a;
  assign rs1_a = instr_i.instr_word[19:15];
  assign rs2_a = instr_i.instr_word[24:20];

  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_wa] <= 1'b1;
    end
  end

  // Operand read with bypass of the write landing at the same edge
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      instr_q <= instr_i.instr_word;
      if (rf_we && rf_wa == rs1_a) rs1_q <= rf_wd;
      else                         rs1_q <= rf_vld_q[rs1_a] ? rf[rs1_a] : reg_reset(rs1_a);
      if (rf_we && rf_wa == rs2_a) rs2_q <= rf_wd;
      else                         rs2_q <= rf_vld_q[rs2_a] ? rf[rs2_a] : reg_reset(rs2_a);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= RESET_PC;
      stop_q      <= ST_OK;
    end else begin
      if (in_acc)     e_valid_q <= 1'b1;
      else if (e_go)  e_valid_q <= 1'b0;
      if (e_go && e_to_m) m_valid_q <= 1'b1;
      else if (m_go)      m_valid_q <= 1'b0;
      if (m_go || e_out)        out_valid_q <= 1'b1;
      else if (result_o.ready)  out_valid_q <= 1'b0;
      if (e_go && e_ok)                  pc_q   <= npc;
      if (e_go && e_run && st != ST_OK)  stop_q <= st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_go && e_to_m) begin
      m_rd_q  <= rd;
      m_f3_q  <= f3;
      m_lo_q  <= off[1:0];
      m_npc_q <= npc;
    end
    if (m_go) begin
      out_status_q <= ST_OK;
      out_npc_q    <= m_npc_q;
      out_wr_q     <= (m_rd_q != '0);
      out_idx_q    <= m_rd_q;
      out_val_q    <= (m_rd_q != '0) ? ld_val : '0;
      out_left_q   <= '0;
      out_right_q  <= '0;
    end else if (e_out) begin
      out_status_q <= e_run ? st : stop_q;
      out_npc_q    <= e_ok ? npc : pc_q;
      out_wr_q     <= e_ok && wr && (rd != '0);
      out_idx_q    <= (e_ok && wr) ? rd : '0;
      out_val_q    <= (e_ok && wr && rd != '0) ? val : '0;
      out_left_q   <= e_run ? left : '0;
      out_right_q  <= e_run ? right : '0;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_status_q;
  assign result_o.next_pc      = out_npc_q;
  assign result_o.wrote_reg    = out_wr_q;
  assign result_o.dest_index   = out_idx_q;
  assign result_o.dest_value   = out_val_q;
  assign result_o.assert_left  = out_left_q;
  assign result_o.assert_right = out_right_q;

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_wa != 5'd0) else $error("write to x0");

  a_mem_drains_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !e_go) else $error("execute advanced past a pending load");

  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy |-> !instr_i.ready) else $error("accept during RAM fill");

  a_stop_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q != ST_OK |=> $stable(stop_q) && $stable(pc_q))
    else $error("stopped state changed");

endmodule

FILE: sim/rv32i_subset_instruction_step_core_tb.sv
// Testbench for the RV32I-subset step core: scoreboard with a behavioral ISA predictor.
module rv32i_subset_instruction_step_core_tb;
  import rv32s_pkg::*;

  localparam int HANG_LIMIT = 100000;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic        wrote_reg;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] assert_left;
    logic [31:0] assert_right;
  } step_res_t;

  // Executes each accepted instruction on its own copy of the core state.
  class step_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] pc;
    logic [7:0]  ram [];
    logic [2:0]  stop_code;
    step_res_t   pending [$];
    int          errors;

    function new();
      ram = new[int'(RAM_BYTES)];
      foreach (ram[i]) ram[i] = RAM_FILL;
      foreach (regs[i]) regs[i] = '0;
      regs[2] = RAM_END;
      regs[3] = RAM_BASE;
      pc = RESET_PC;
      stop_code = ST_OK;
      errors = 0;
    endfunction

    function bit ram_off(logic [31:0] addr, int size, output int off);
      logic [31:0] o;
      o = addr - RAM_BASE;
      off = int'(o);
      return longint'(o) + size <= longint'(RAM_BYTES);
    endfunction

    function logic [31:0] alu(logic [2:0] f3, logic [31:0] a, logic [31:0] b,
                              bit arith, bit sub);
      logic [4:0] sh;
      sh = b[4:0];
      case (f3)
        3'd0: return sub ? a - b : a + b;
        3'd1: return a << sh;
        3'd2: return {31'b0, $signed(a) < $signed(b)};
        3'd3: return {31'b0, a < b};
        3'd4: return a ^ b;
        3'd5: return arith ? 32'($signed(a) >>> sh) : a >> sh;
        3'd6: return a | b;
        default: return a & b;
      endcase
    endfunction

    function void note(logic [31:0] w);
      step_res_t   r;
      logic [6:0]  opc;
      logic [2:0]  f3, st;
      logic [6:0]  f7;
      logic [4:0]  rd;
      logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, npc, val;
      bit          wr, take;
      int          size, off;
      opc = w[6:0]; f3 = w[14:12]; f7 = w[31:25]; rd = w[11:7];
      a = regs[w[19:15]]; b = regs[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      npc = pc + 4; val = '0; wr = 0; st = ST_OK;
      r = '{ST_OK, '0, 1'b0, '0, '0, '0, '0};
      if (stop_code != ST_OK) begin
        r.status = stop_code;
        r.next_pc = pc;
        pending.push_back(r);
        return;
      end
      case (opc)
        OPC_OP: begin
          if (f7 != 0 && (f3 != 0 || f7 != FUNCT7_SUB)) st = ST_BADFN;
          else begin
            val = alu(f3, a, b, 0, f7 == FUNCT7_SUB);
            wr = 1;
          end
        end
        OPC_OP_IMM: begin
          val = alu(f3, a, imm_i, w[30], 0);
          wr = 1;
        end
        OPC_LOAD: begin
          size = (f3[1:0] == 0) ? 1 : (f3[1:0] == 1) ? 2 : 4;
          if (f3 == 3 || f3 == 6 || f3 == 7) st = ST_BADFN;
          else if (!ram_off(a + imm_i, size, off)) st = ST_RANGE;
          else begin
            for (int i = 0; i < size; i++) val[8*i +: 8] = ram[off + i];
            if (f3 < 4 && size == 1) val = {{24{val[7]}}, val[7:0]};
            if (f3 < 4 && size == 2) val = {{16{val[15]}}, val[15:0]};
            wr = 1;
          end
        end
        OPC_STORE: begin
          size = (f3 == 0) ? 1 : (f3 == 1) ? 2 : 4;
          if (f3 > 2) st = ST_BADFN;
          else if (!ram_off(a + imm_s, size, off)) st = ST_RANGE;
          else for (int i = 0; i < size; i++) ram[off + i] = b[8*i +: 8];
        end
        OPC_BRANCH: begin
          take = 0;
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: st = ST_BADFN;
          endcase
          if (take) npc = pc + imm_b;
        end
        OPC_JAL: begin
          val = pc + 4; wr = 1; npc = pc + imm_j;
        end
        OPC_JALR: begin
          npc = a + imm_i; val = pc + 4; wr = 1;
        end
        OPC_LUI: begin
          val = w & LUI_MASK; wr = 1;
        end
        OPC_CUSTOM: begin
          if (f3 == 0) begin
            if (a != b) begin
              st = ST_ASSERT; r.assert_left = a; r.assert_right = b;
            end
          end else if (f3 == 7) st = ST_HALT;
          else st = ST_BADFN;
        end
        default: st = ST_BADOP;
      endcase
      if (st != ST_OK) begin
        stop_code = st;
        r.status = st;
        r.next_pc = pc;
      end else begin
        if (wr && rd != 0) begin
          regs[rd] = val;
          r.wrote_reg = 1; r.dest_index = rd; r.dest_value = val;
        end
        pc = npc;
        r.next_pc = npc;
      end
      pending.push_back(r);
    endfunction

    function void check(step_res_t got);
      step_res_t want;
      if (pending.size() == 0) begin
        $error("result with no instruction outstanding: status %0d pc %h",
               got.status, got.next_pc);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %h actual %h", want.status, got.status); errors++;
      end
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc: expected %h actual %h", want.next_pc, got.next_pc); errors++;
      end
      if (got.wrote_reg !== want.wrote_reg) begin
        $error("wrote_reg: expected %h actual %h", want.wrote_reg, got.wrote_reg); errors++;
      end
      if (got.dest_index !== want.dest_index) begin
        $error("dest_index: expected %h actual %h", want.dest_index, got.dest_index);
        errors++;
      end
      if (got.dest_value !== want.dest_value) begin
        $error("dest_value: expected %h actual %h", want.dest_value, got.dest_value);
        errors++;
      end
      if (got.assert_left !== want.assert_left) begin
        $error("assert_left: expected %h actual %h", want.assert_left, got.assert_left);
        errors++;
      end
      if (got.assert_right !== want.assert_right) begin
        $error("assert_right: expected %h actual %h", want.assert_right, got.assert_right);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   snk_stall_pct;
  bit   hold_req;
  int   quiet_cycles;
  step_scoreboard sb = new();

  rv32s_instr_if  instr_ch ();
  rv32s_result_if res_ch ();

  rv32i_subset_instruction_step_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (instr_ch),
    .result_o (res_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // Load or store that stays inside RAM; falls back to a pointer LUI when no
  // register is close enough to the RAM window.
  function automatic logic [31:0] gen_mem(bit is_store);
    logic [2:0]  f3;
    logic [4:0]  rs1, rd;
    logic [31:0] a;
    longint      lo, hi, imm;
    int          size;
    f3 = is_store ? 3'($urandom_range(0, 2)) : 3'({$urandom_range(0, 5)} + 0);
    if (!is_store && f3 == 3) f3 = 3'd4;
    size = (f3[1:0] == 0) ? 1 : (f3[1:0] == 1) ? 2 : 4;
    rd = 5'($urandom);
    for (int t = 0; t < 8; t++) begin
      rs1 = 5'($urandom);
      a = sb.regs[rs1];
      lo = longint'(RAM_BASE) - longint'(a);
      hi = longint'(RAM_END) - size - longint'(a);
      if (lo < -2048) lo = -2048;
      if (hi > 2047) hi = 2047;
      if (lo <= hi) begin
        imm = lo + longint'($urandom_range(0, 32'(hi - lo)));
        return is_store ? enc_s(12'(imm), 5'($urandom), rs1, f3)
                        : enc_i(12'(imm), rs1, f3, rd, OPC_LOAD);
      end
    end
    a = RAM_BASE + (($urandom_range(0, 9) < 8 ? $urandom_range(0, 1)
                                              : $urandom_range(0, 15)) << 12);
    return {a[31:12], 5'($urandom_range(1, 31)), OPC_LUI};
  endfunction

  function automatic logic [31:0] gen_legal();
    int          pick;
    logic [2:0]  f3;
    logic [4:0]  rs;
    pick = $urandom_range(0, 99);
    f3 = 3'($urandom);
    if (pick < 20)
      return enc_r((f3 == 0 && $urandom_range(0, 1)) ? FUNCT7_SUB : 7'd0,
                   5'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OP);
    if (pick < 40) return enc_i(12'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OP_IMM);
    if (pick < 58) return gen_mem(0);
    if (pick < 72) return gen_mem(1);
    if (pick < 82) begin
      if (f3 == 2 || f3 == 3) f3 = f3 + 3'd4;
      return enc_b(13'($urandom), 5'($urandom), 5'($urandom), f3);
    end
    if (pick < 86) return enc_j(21'($urandom), 5'($urandom));
    if (pick < 90) return enc_i(12'($urandom), 5'($urandom), f3, 5'($urandom), OPC_JALR);
    if (pick < 95) return {20'($urandom), 5'($urandom), OPC_LUI};
    // assert-equal on one register always passes
    rs = 5'($urandom);
    return enc_r(7'($urandom), rs, rs, 3'd0, 5'($urandom), OPC_CUSTOM);
  endfunction

  task automatic send(logic [31:0] w);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      instr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    instr_ch.valid      <= 1'b1;
    instr_ch.instr_word <= w;
    do @(posedge clk_i); while (!instr_ch.ready);
    sb.note(w);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) send(gen_legal());
  endtask

  // Stop the core with one randomly chosen terminal condition.
  task automatic send_terminal();
    case ($urandom_range(0, 4))
      0: send(enc_i(12'd0, 5'd0, 3'd7, 5'd0, OPC_CUSTOM));
      1: begin
        send(enc_i(12'd1, 5'd0, 3'd0, 5'd5, OPC_OP_IMM));
        send(enc_r(7'd0, 5'd0, 5'd5, 3'd0, 5'd0, OPC_CUSTOM));
      end
      2: send({20'($urandom), 5'($urandom), 7'b0010111});  // AUIPC
      3: case ($urandom_range(0, 5))
        0: send(enc_r(7'd1, 5'd1, 5'd2, 3'd1, 5'd3, OPC_OP));
        1: send(enc_r(7'd1, 5'd1, 5'd2, 3'd0, 5'd3, OPC_OP));
        2: send(enc_i(12'd0, 5'd3, 3'd7, 5'd4, OPC_LOAD));
        3: send(enc_s(12'd0, 5'd4, 5'd3, 3'd5));
        4: send(enc_b(13'd8, 5'd1, 5'd2, 3'd2));
        default: send(enc_i(12'd0, 5'd1, 3'd3, 5'd0, OPC_CUSTOM));
      endcase
      default: send(enc_i(12'hFFC, 5'd0, 3'd2, 5'd6, OPC_LOAD));
    endcase
    repeat (3) send($urandom);
  endtask

  initial begin
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = '0;
    res_ch.ready        = 1'b0;
    rst_ni              = 1'b0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    hold_req            = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send({20'hFFFFF, 5'd1, OPC_LUI});
    send(enc_i(12'h800, 5'd0, 3'd0, 5'd4, OPC_OP_IMM));
    send(enc_i(12'h7FF, 5'd0, 3'd0, 5'd5, OPC_OP_IMM));
    send(enc_i(12'd1, 5'd5, 3'd0, 5'd0, OPC_OP_IMM));      // x0 stays zero
    send(enc_r(FUNCT7_SUB, 5'd5, 5'd4, 3'd0, 5'd7, OPC_OP));
    send(enc_i(12'd31, 5'd5, 3'd1, 5'd8, OPC_OP_IMM));
    send(enc_i(12'h41F, 5'd1, 3'd5, 5'd9, OPC_OP_IMM));     // arithmetic right shift
    send(enc_i(12'd4, 5'd1, 3'd5, 5'd10, OPC_OP_IMM));
    send(enc_r(7'd0, 5'd5, 5'd1, 3'd2, 5'd11, OPC_OP));
    send(enc_r(7'd0, 5'd5, 5'd1, 3'd3, 5'd12, OPC_OP));
    send(enc_i(12'hFFF, 5'd1, 3'd4, 5'd13, OPC_OP_IMM));
    send(enc_r(7'd0, 5'd5, 5'd4, 3'd6, 5'd14, OPC_OP));
    send(enc_r(7'd0, 5'd5, 5'd1, 3'd7, 5'd15, OPC_OP));
    send(enc_s(12'd1, 5'd7, 5'd3, 3'd2));                   // unaligned word store
    send(enc_i(12'd1, 5'd3, 3'd2, 5'd16, OPC_LOAD));
    send(enc_i(12'd3, 5'd3, 3'd1, 5'd17, OPC_LOAD));
    send(enc_i(12'd6, 5'd3, 3'd5, 5'd18, OPC_LOAD));        // still 0xAA fill
    send(enc_s(12'hFFF, 5'd5, 5'd2, 3'd0));                 // last RAM byte
    send(enc_i(12'hFFF, 5'd2, 3'd0, 5'd19, OPC_LOAD));
    send(enc_i(12'hFFC, 5'd2, 3'd4, 5'd20, OPC_LOAD));
    send(enc_b(13'h1FF8, 5'd0, 5'd0, 3'd0));
    send(enc_b(13'd8, 5'd5, 5'd1, 3'd4));
    send(enc_b(13'd8, 5'd5, 5'd1, 3'd7));
    send(enc_j(21'h100000, 5'd21));
    send(enc_i(12'd0, 5'd5, 3'd0, 5'd22, OPC_JALR));        // odd target kept
    send(enc_r(7'd0, 5'd5, 5'd5, 3'd0, 5'd0, OPC_CUSTOM));

    hold_req = 1;
    run_phase(380, 0, 0);
    run_phase(380, 73, 0);
    run_phase(380, 0, 73);
    run_phase(380, 73, 73);
    run_phase(30, 7, 7);
    send_terminal();
    // Drop valid at the accepting edge so the last word is not taken twice
    instr_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back up the core.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready)
      sb.check('{res_ch.status, res_ch.next_pc, res_ch.wrote_reg, res_ch.dest_index,
                 res_ch.dest_value, res_ch.assert_left, res_ch.assert_right});
  end

  // Hang detection: the limit leaves room for the fill pass after reset.
  always @(posedge clk_i) begin
    if ((instr_ch.valid && instr_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial quiet_cycles = 0;

endmodule
